// ----- hw/rtl/buddy_block_allocator_defines.svh -----
// Assertion macros used by the buddy allocator top level.
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define BBA_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define BBA_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hw/rtl/bba_pkg.sv -----
// Package with the node mark codes, commands and controller interface types.
package bba_pkg;
  localparam logic [1:0] MARK_UNUSED = 2'd0;
  localparam logic [1:0] MARK_FREE   = 2'd1;
  localparam logic [1:0] MARK_SPLIT  = 2'd2;
  localparam logic [1:0] MARK_ALLOC  = 2'd3;
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;
  // Walk moves; on a result load LEFT picks the start and RIGHT the remaining units.
  localparam logic [1:0] SEL_PARENT = 2'd0;
  localparam logic [1:0] SEL_LEFT   = 2'd1;
  localparam logic [1:0] SEL_RIGHT  = 2'd2;
  localparam logic [1:0] SEL_BUDDY  = 2'd3;
  localparam int unsigned ReqW = 11;
  localparam int unsigned IdxW = 10;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the request
    logic clear_wr;  // write one clearing entry
    logic clear_inc; // advance clearing address
    logic rd;        // read the mark at the current address
    logic wr;        // write wr_mark at the current address
    logic [1:0] wr_mark;
    logic go_node;   // move to a chosen node address
    logic [1:0] sel; // parent, left child, right child or buddy
    logic res_ok;    // register a success result
    logic res_fail;  // register a failure result
    logic set_found; // free matched
  } bba_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_done;
    logic [1:0] rd_mark;
    logic is_root;
    logic is_left;
    logic half_fits;  // half span still holds the request
    logic span_fits;
    logic idx_start;  // node start equals the index
    logic idx_in;     // index lies inside the node
    logic idx_right;  // index lies in the right half
    logic found;
  } bba_sts_t;
endpackage

// ----- hw/rtl/bba_datapath.sv -----
// Datapath: node mark memory, tree walk registers and result register.
module bba_datapath
  import bba_pkg::*;
#(
  parameter int unsigned POOL_UNITS = 1024,
  parameter int unsigned POOL_COUNT = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  bba_cmd_t        cmd_i,
  output bba_sts_t        sts_o,
  input  logic            pool_i,
  input  logic [ReqW-1:0] req_i,
  input  logic [IdxW-1:0] idx_i,
  output logic            res_status_o,
  output logic [ReqW-1:0] res_value_o
);
  localparam int unsigned Lv   = $clog2(POOL_UNITS);
  localparam int unsigned NW   = Lv + 1;
  localparam int unsigned PW   = (POOL_COUNT > 1) ? 1 : 0;
  localparam int unsigned AW   = NW + PW;
  localparam int unsigned Dep  = 1 << AW;
  localparam int unsigned SW   = Lv + 1;

  logic [1:0]      mem_q [Dep];
  logic [1:0]      rd_q;
  logic [NW-1:0]   node_q, node_d;
  logic [SW-1:0]   start_q, start_d, span_q, span_d;
  logic [SW-1:0]   want_q, idx_q;
  logic            pool_q, found_q, idx_out_q;
  logic [AW:0]     clr_q;
  logic [AW-1:0]   addr;
  logic [ReqW-1:0] want_in;
  logic            want_big;
  logic            pool_bad;

  // Pool selection joins the node number to form the memory address.
  if (PW == 1) begin : g_pool
    assign addr = {pool_q, node_q};
  end else begin : g_nopool
    assign addr = node_q;
  end

  // Request capture with zero taken as one; oversize requests never fit.
  assign want_in  = (req_i == '0) ? ReqW'(1) : req_i;
  assign pool_bad = (POOL_COUNT < 2) && pool_i;
  assign want_big = (32'(want_in) > POOL_UNITS) || pool_bad;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.clear_inc) clr_q <= clr_q + 1'b1;
      if (cmd_i.load) found_q <= 1'b0;
      else if (cmd_i.set_found) found_q <= 1'b1;
    end
  end

  // Mark memory: one clearing write, or one walk write, and a registered read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clear_wr) begin
      mem_q[clr_q[AW-1:0]] <= (clr_q[NW-1:0] == NW'(1)) ? MARK_FREE : MARK_UNUSED;
    end else if (cmd_i.wr) begin
      mem_q[addr] <= cmd_i.wr_mark;
    end
    if (cmd_i.rd) rd_q <= mem_q[addr];
  end

  // Next node, start and span for each walk move.
  always_comb begin
    node_d  = node_q;
    start_d = start_q;
    span_d  = span_q;
    case (cmd_i.sel)
      SEL_PARENT: begin
        node_d  = node_q >> 1;
        span_d  = span_q << 1;
        start_d = start_q & ~span_q;
      end
      SEL_LEFT: begin
        node_d = {node_q[NW-2:0], 1'b0};
        span_d = span_q >> 1;
      end
      SEL_RIGHT: begin
        node_d  = {node_q[NW-2:0], 1'b1};
        span_d  = span_q >> 1;
        start_d = start_q + (span_q >> 1);
      end
      default: begin
        node_d  = node_q ^ NW'(1);
        start_d = start_q ^ span_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      node_q    <= NW'(1);
      start_q   <= '0;
      span_q    <= SW'(POOL_UNITS);
      pool_q    <= pool_i;
      idx_q     <= SW'(idx_i);
      idx_out_q <= (32'(idx_i) >= POOL_UNITS);
      want_q    <= want_big ? '1 : SW'(want_in);
    end else if (cmd_i.go_node) begin
      node_q  <= node_d;
      start_q <= start_d;
      span_q  <= span_d;
    end
    if (cmd_i.res_ok) begin
      res_status_o <= 1'b0;
      case (cmd_i.sel)
        SEL_LEFT:  res_value_o <= ReqW'(start_q);
        SEL_RIGHT: res_value_o <= ReqW'(start_q + span_q - idx_q);
        default:   res_value_o <= '0;
      endcase
    end else if (cmd_i.res_fail) begin
      res_status_o <= 1'b1;
      res_value_o  <= '0;
    end
  end

  // Status for the controller.
  always_comb begin
    sts_o.clear_done = clr_q[AW];
    sts_o.rd_mark    = rd_q;
    sts_o.is_root    = (node_q == NW'(1));
    sts_o.is_left    = ~node_q[0];
    sts_o.half_fits  = ((span_q >> 1) >= want_q) && (span_q != SW'(1));
    sts_o.span_fits  = (span_q >= want_q) && (want_q != '1 || POOL_UNITS == 0);
    sts_o.idx_start  = (start_q == idx_q) && !idx_out_q;
    sts_o.idx_in     = (idx_q >= start_q) && ((idx_q - start_q) < span_q) && !idx_out_q;
    sts_o.idx_right  = ((idx_q - start_q) >= (span_q >> 1));
    sts_o.found      = found_q;
  end
endmodule

// ----- hw/rtl/bba_ctrl.sv -----
// Controller state machine that walks the tree for each request.
module bba_ctrl
  import bba_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] cmd_code_i,
  input  logic       out_full_i,
  output logic       out_load_o,
  input  bba_sts_t   sts_i,
  output bba_cmd_t   cmd_o
);
  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_EVAL  = 4'd3;
  localparam logic [3:0] S_UP    = 4'd4;
  localparam logic [3:0] S_BRD   = 4'd5;
  localparam logic [3:0] S_BEV   = 4'd6;
  localparam logic [3:0] S_SPW   = 4'd7;
  localparam logic [3:0] S_DONE  = 4'd8;
  localparam logic [3:0] S_SPL   = 4'd9;
  localparam logic [3:0] S_SPR   = 4'd10;
  localparam logic [3:0] S_LRD   = 4'd11;
  localparam logic [3:0] S_LEV   = 4'd12;
  localparam logic [3:0] S_MRR   = 4'd13;
  localparam logic [3:0] S_MRC   = 4'd14;
  localparam logic [3:0] S_MRP   = 4'd15;

  logic [3:0] state_q, state_d;
  logic [1:0] op_q, op_d;
  logic       ok_q, ok_d;
  logic       back_q, back_d; // right child of the pair is free

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      op_q    <= CMD_ALLOC;
      ok_q    <= 1'b0;
      back_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      ok_q    <= ok_d;
      back_q  <= back_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    ok_d       = ok_q;
    back_d     = back_q;
    cmd_o      = '0;
    out_load_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clear_wr  = 1'b1;
        cmd_o.clear_inc = 1'b1;
        if (sts_i.clear_done) begin
          cmd_o.clear_wr  = 1'b0;
          cmd_o.clear_inc = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          op_d   = cmd_code_i;
          ok_d   = 1'b0;
          back_d = 1'b0;
          state_d = (cmd_code_i == CMD_NONE) ? S_DONE : S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = S_EVAL;
      end
      S_EVAL: begin
        // Decide at the current node by its mark.
        if (sts_i.rd_mark == MARK_SPLIT) begin
          cmd_o.go_node = 1'b1;
          if (op_q == CMD_QUERY)
            cmd_o.sel = sts_i.idx_right ? SEL_RIGHT : SEL_LEFT;
          else
            cmd_o.sel = SEL_LEFT;
          state_d = S_RD;
        end else if (op_q == CMD_ALLOC && sts_i.rd_mark == MARK_FREE && sts_i.span_fits) begin
          if (sts_i.half_fits) begin
            cmd_o.wr = 1'b1; cmd_o.wr_mark = MARK_SPLIT;
            state_d = S_SPL;
          end else begin
            cmd_o.wr = 1'b1; cmd_o.wr_mark = MARK_ALLOC;
            ok_d = 1'b1;
            state_d = S_DONE;
          end
        end else if (op_q == CMD_QUERY) begin
          ok_d = (sts_i.rd_mark == MARK_ALLOC) && sts_i.idx_in;
          state_d = S_DONE;
        end else begin
          if (op_q == CMD_FREE && sts_i.rd_mark == MARK_ALLOC && sts_i.idx_start) begin
            cmd_o.wr = 1'b1; cmd_o.wr_mark = MARK_FREE;
            cmd_o.set_found = 1'b1;
          end
          state_d = S_UP;
        end
      end
      S_SPL: begin
        cmd_o.go_node = 1'b1; cmd_o.sel = SEL_RIGHT;
        state_d = S_SPR;
      end
      S_SPR: begin
        // Mark the right child free, then move to the left child.
        cmd_o.wr = 1'b1; cmd_o.wr_mark = MARK_FREE;
        cmd_o.go_node = 1'b1; cmd_o.sel = SEL_BUDDY;
        state_d = S_SPW;
      end
      S_SPW: begin
        // Left child of a fresh split: mark it free, then evaluate it.
        cmd_o.wr = 1'b1; cmd_o.wr_mark = MARK_FREE;
        state_d = S_RD;
      end
      S_UP: begin
        // Leaving a finished subtree: finish at the root, go to the right sibling or climb.
        if (sts_i.is_root) begin
          ok_d = (op_q == CMD_FREE) && sts_i.found;
          state_d = S_DONE;
        end else if (sts_i.is_left) begin
          cmd_o.go_node = 1'b1; cmd_o.sel = SEL_BUDDY;
          state_d = S_RD;
        end else begin
          state_d = S_BRD;
        end
      end
      S_BRD: begin
        cmd_o.rd = 1'b1;
        state_d = S_BEV;
      end
      S_BEV: begin
        // At the right child; a free checks the pair for a merge before climbing.
        if (op_q == CMD_FREE) begin
          cmd_o.go_node = 1'b1; cmd_o.sel = SEL_BUDDY;
          back_d = 1'b0;
          state_d = S_LRD;
        end else begin
          cmd_o.go_node = 1'b1; cmd_o.sel = SEL_PARENT;
          state_d = S_UP;
        end
      end
      S_LRD: begin
        // Read the left child and keep whether the right child is free.
        cmd_o.rd = 1'b1; state_d = S_LEV;
        back_d = (sts_i.rd_mark == MARK_FREE);
      end
      S_LEV: begin
        if (back_q && sts_i.rd_mark == MARK_FREE) begin
          cmd_o.wr = 1'b1; cmd_o.wr_mark = MARK_UNUSED;
          state_d = S_MRR;
        end else begin
          cmd_o.go_node = 1'b1; cmd_o.sel = SEL_PARENT;
          state_d = S_UP;
        end
      end
      S_MRR: begin
        cmd_o.go_node = 1'b1; cmd_o.sel = SEL_BUDDY;
        state_d = S_MRC;
      end
      S_MRC: begin
        cmd_o.wr = 1'b1; cmd_o.wr_mark = MARK_UNUSED;
        cmd_o.go_node = 1'b1; cmd_o.sel = SEL_PARENT;
        state_d = S_MRP;
      end
      S_MRP: begin
        cmd_o.wr = 1'b1; cmd_o.wr_mark = MARK_FREE;
        state_d = S_UP;
      end
      S_DONE: begin
        if (!out_full_i) begin
          out_load_o = 1'b1;
          if (ok_q) begin
            cmd_o.res_ok = 1'b1;
            cmd_o.sel = (op_q == CMD_ALLOC) ? SEL_LEFT :
                        (op_q == CMD_QUERY) ? SEL_RIGHT : SEL_PARENT;
          end else begin
            cmd_o.res_fail = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// ----- hw/rtl/buddy_block_allocator.sv -----
// Top level of the binary buddy allocator.
// Each request (allocate, free, query) is taken in the idle state, walks the
// node mark tree with at most one memory read or write a cycle and ends by
// loading the result register. Each node visited is read, then evaluated.
// Allocate splits a free node too large for the request: marks it split, then
// its right and left children free. Backing out of a subtree moves from a left
// child to its sibling, or reads a right child and climbs. Free walks every
// split node of the pool; at a right child it merges a free buddy pair into
// its parent. A request whose result finds the output register still unread
// waits for it. After reset a clearing pass writes the mark memory before the
// first request is taken.
`include "buddy_block_allocator_defines.svh"
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned POOL_UNITS = 1024,
  parameter int unsigned POOL_COUNT = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] command, [2] pool_select, [13:3] request_units, [23:14] unit_index
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [0] status, [11:1] result_value
  output logic [15:0] m_axis_tdata
);
  bba_cmd_t        cmd;
  bba_sts_t        sts;
  logic            out_load, full_q, res_status;
  logic [ReqW-1:0] res_value;
  logic [1:0]      cmd_code;

  // A pool beyond the configured count is refused like an unknown command.
  assign cmd_code = (POOL_COUNT < 2 && s_axis_tdata[2]) ? CMD_NONE : s_axis_tdata[1:0];

  bba_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_code_i (cmd_code),
    .out_full_i (full_q && !m_axis_tready),
    .out_load_o (out_load),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  bba_datapath #(.POOL_UNITS(POOL_UNITS), .POOL_COUNT(POOL_COUNT)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i        (cmd),
    .sts_o        (sts),
    .pool_i       (s_axis_tdata[2]),
    .req_i        (s_axis_tdata[13:3]),
    .idx_i        (s_axis_tdata[23:14]),
    .res_status_o (res_status),
    .res_value_o  (res_value)
  );

  // Output valid register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else if (out_load) full_q <= 1'b1;
    else if (m_axis_tready) full_q <= 1'b0;
  end

  assign m_axis_tvalid = full_q;
  assign m_axis_tdata  = {4'd0, res_value, res_status};

  `BBA_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, out_load, !full_q || m_axis_tready)
  `BBA_ASSERT_NXT(a_load_valid, clk_i, rst_ni, out_load, m_axis_tvalid)
  `BBA_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[0],
                  m_axis_tdata[11:1] == '0)
endmodule
